// ===== design/dq_pkg.sv =====
// Shared types, codes and sizing helpers for the double-ended queue with membership search.
// Used by the interfaces, the cell, the OR tree, the top level and the checker.
`default_nettype none

package dq_pkg;

  localparam int DQ_DEPTH      = 16;
  localparam int DQ_DATA_WIDTH = 32;
  localparam int MODE_WIDTH    = 3;
  localparam int VALUE_WIDTH   = 32;
  localparam int STATUS_WIDTH  = 2;
  localparam int TREE_FANIN    = 8;

  typedef enum logic [MODE_WIDTH-1:0] {
    MODE_PUSH_FRONT = 3'd0,
    MODE_PUSH_BACK  = 3'd1,
    MODE_POP_FRONT  = 3'd2,
    MODE_POP_BACK   = 3'd3,
    MODE_QUERY      = 3'd4
  } mode_t;

  typedef enum logic [STATUS_WIDTH-1:0] {
    STATUS_OK    = 2'd0,
    STATUS_EMPTY = 2'd1,
    STATUS_FULL  = 2'd2
  } status_t;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUSH_FRONT,
    OP_PUSH_BACK,
    OP_POP_FRONT,
    OP_POP_BACK,
    OP_QUERY
  } op_t;

  typedef enum logic {
    ST_IDLE,
    ST_REDUCE
  } state_t;

  // Number of registered levels needed to fold n leaves down to one.
  function automatic int tree_levels(int n);
    int lv;
    int s;
    lv = 0;
    s  = n;
    while (s > 1) begin
      s  = (s + TREE_FANIN - 1) / TREE_FANIN;
      lv = lv + 1;
    end
    return lv;
  endfunction

endpackage

`default_nettype wire

// ===== design/dq_if.sv =====
// Valid/ready channel interfaces for request beats and result beats.
// Depends on dq_pkg for the field widths.
`default_nettype none

interface dq_in_if;
  logic                             valid;
  logic                             ready;
  logic [dq_pkg::MODE_WIDTH-1:0]    mode;
  logic [dq_pkg::VALUE_WIDTH-1:0]   value;

  modport source (output valid, output mode, output value, input ready);
  modport sink   (input valid, input mode, input value, output ready);
endinterface

interface dq_out_if;
  logic                             valid;
  logic                             ready;
  logic [dq_pkg::VALUE_WIDTH-1:0]   popped_value;
  logic                             found;
  logic [dq_pkg::STATUS_WIDTH-1:0]  status;

  modport source (output valid, output popped_value, output found, output status, input ready);
  modport sink   (input valid, input popped_value, input found, input status, output ready);
endinterface

`default_nettype wire

// ===== design/dq_cell.sv =====
// One storage cell of the shifting queue row: holds a word and its occupied flag.
// Depends on dq_pkg for the operation codes.
`default_nettype none

module dq_cell #(
  parameter int DATA_WIDTH = dq_pkg::DQ_DATA_WIDTH,
  parameter bit FIRST      = 1'b0
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire dq_pkg::op_t           op,
  input  wire logic [DATA_WIDTH-1:0] word,
  input  wire logic [DATA_WIDTH-1:0] left_data,
  input  wire logic                  left_valid,
  input  wire logic [DATA_WIDTH-1:0] right_data,
  input  wire logic                  right_valid,
  output logic [DATA_WIDTH-1:0]      data_o,
  output logic                       valid_o,
  output logic [DATA_WIDTH:0]        contrib
);

  logic [DATA_WIDTH-1:0] data_r;
  logic [DATA_WIDTH-1:0] data_nxt;
  logic                  valid_r;
  logic                  valid_nxt;

  always_comb begin
    data_nxt  = data_r;
    valid_nxt = valid_r;
    contrib   = '0;
    unique case (op)
      dq_pkg::OP_PUSH_FRONT: begin
        data_nxt  = left_data;
        valid_nxt = left_valid;
      end
      dq_pkg::OP_PUSH_BACK: begin
        if (!valid_r && left_valid) begin
          data_nxt  = word;
          valid_nxt = 1'b1;
        end
      end
      dq_pkg::OP_POP_FRONT: begin
        data_nxt  = right_data;
        valid_nxt = right_valid;
        if (FIRST && valid_r) begin
          contrib = {1'b0, data_r};
        end
      end
      dq_pkg::OP_POP_BACK: begin
        if (valid_r && !right_valid) begin
          valid_nxt = 1'b0;
          contrib   = {1'b0, data_r};
        end
      end
      dq_pkg::OP_QUERY: begin
        if (valid_r && (data_r == word)) begin
          contrib = {1'b1, {DATA_WIDTH{1'b0}}};
        end
      end
      dq_pkg::OP_NONE: begin
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    data_r <= data_nxt;
  end

  assign data_o  = data_r;
  assign valid_o = valid_r;

endmodule

`default_nettype wire

// ===== design/dq_or_tree.sv =====
// Registered OR reduction tree that gathers the answers of all cells.
// Depends on dq_pkg for the fan-in and the level count.
`default_nettype none

module dq_or_tree #(
  parameter int N = dq_pkg::DQ_DEPTH,
  parameter int W = dq_pkg::DQ_DATA_WIDTH + 1
) (
  input  wire logic         clk,
  input  wire logic         load,
  input  wire logic [W-1:0] leaf [N],
  output logic [W-1:0]      root
);

  localparam int LEVELS = dq_pkg::tree_levels(N);

  logic [W-1:0] lvl_r [LEVELS+1][N];

  always_ff @(posedge clk) begin
    logic [W-1:0] acc;
    if (load) begin
      for (int j = 0; j < N; j++) begin
        lvl_r[0][j] <= leaf[j];
      end
    end
    for (int k = 0; k < LEVELS; k++) begin
      for (int j = 0; j < N; j++) begin
        acc = '0;
        for (int t = 0; t < dq_pkg::TREE_FANIN; t++) begin
          if (j * dq_pkg::TREE_FANIN + t < N) begin
            acc = acc | lvl_r[k][j * dq_pkg::TREE_FANIN + t];
          end
        end
        lvl_r[k+1][j] <= acc;
      end
    end
  end

  assign root = lvl_r[LEVELS][0];

endmodule

`default_nettype wire

// ===== design/deque_with_membership_search.sv =====
// Top level of the double-ended queue with membership search.
// Depends on dq_pkg, dq_if, dq_cell and dq_or_tree.
//
// The queue is a row of DEPTH cells packed from the front: pushes and pops at the front shift
// the whole row by one cell, while pushes and pops at the back touch only the cell at the end of
// the occupied run. Every cell also compares its word with the search value, and the cells'
// answers are gathered by a registered OR tree with a fan-in of eight. One request beat is in
// flight at a time: its result beat is registered once the cells' answers have passed the leaf
// registers and every level of the OR tree, and the next request is taken only once that result
// has been taken. The depth of the OR tree thus sets how long a beat lasts. Entries need
// no clearing after reset; the block takes requests from the first cycle out of reset.
`default_nettype none

module deque_with_membership_search #(
  parameter int DEPTH      = dq_pkg::DQ_DEPTH,
  parameter int DATA_WIDTH = dq_pkg::DQ_DATA_WIDTH
) (
  input  wire logic clk,
  input  wire logic rst_n,
  dq_in_if.sink     in_beat,
  dq_out_if.source  out_beat
);

  localparam int LEVELS = dq_pkg::tree_levels(DEPTH);
  localparam int CNT_W  = $clog2(LEVELS + 1);
  localparam int VW     = dq_pkg::VALUE_WIDTH;

  dq_pkg::state_t          state_r;
  dq_pkg::state_t          state_nxt;
  logic [CNT_W-1:0]        cnt_r;
  logic                    accept;
  logic                    tree_done;
  dq_pkg::op_t             op;
  dq_pkg::status_t         status_nxt;
  dq_pkg::status_t         status_r;
  logic [DATA_WIDTH-1:0]   word;
  logic [DATA_WIDTH-1:0]   cell_data    [DEPTH];
  logic [DEPTH-1:0]        cell_valid;
  logic [DATA_WIDTH:0]     cell_contrib [DEPTH];
  logic [DATA_WIDTH:0]     root;
  logic [VW-1:0]           popped;
  logic                    out_valid_r;
  logic [VW-1:0]           out_popped_r;
  logic                    out_found_r;
  logic [dq_pkg::STATUS_WIDTH-1:0] out_status_r;

  generate
    if (DATA_WIDTH > VW) begin : g_wide
      assign word   = {{(DATA_WIDTH-VW){1'b0}}, in_beat.value};
      assign popped = root[VW-1:0];
    end else if (DATA_WIDTH == VW) begin : g_same
      assign word   = in_beat.value;
      assign popped = root[VW-1:0];
    end else begin : g_narrow
      assign word   = in_beat.value[DATA_WIDTH-1:0];
      assign popped = {{(VW-DATA_WIDTH){1'b0}}, root[DATA_WIDTH-1:0]};
    end
  endgenerate

  assign accept = in_beat.valid && in_beat.ready;

  always_comb begin
    op         = dq_pkg::OP_NONE;
    status_nxt = dq_pkg::STATUS_OK;
    if (accept) begin
      unique case (dq_pkg::mode_t'(in_beat.mode))
        dq_pkg::MODE_PUSH_FRONT: begin
          if (cell_valid[DEPTH-1]) begin
            status_nxt = dq_pkg::STATUS_FULL;
          end else begin
            op = dq_pkg::OP_PUSH_FRONT;
          end
        end
        dq_pkg::MODE_PUSH_BACK: begin
          if (cell_valid[DEPTH-1]) begin
            status_nxt = dq_pkg::STATUS_FULL;
          end else begin
            op = dq_pkg::OP_PUSH_BACK;
          end
        end
        dq_pkg::MODE_POP_FRONT: begin
          if (!cell_valid[0]) begin
            status_nxt = dq_pkg::STATUS_EMPTY;
          end else begin
            op = dq_pkg::OP_POP_FRONT;
          end
        end
        dq_pkg::MODE_POP_BACK: begin
          if (!cell_valid[0]) begin
            status_nxt = dq_pkg::STATUS_EMPTY;
          end else begin
            op = dq_pkg::OP_POP_BACK;
          end
        end
        dq_pkg::MODE_QUERY: begin
          op = dq_pkg::OP_QUERY;
        end
        default: begin
        end
      endcase
    end
  end

  generate
    for (genvar i = 0; i < DEPTH; i++) begin : g_cell
      logic [DATA_WIDTH-1:0] left_data;
      logic                  left_valid;
      logic [DATA_WIDTH-1:0] right_data;
      logic                  right_valid;

      if (i == 0) begin : g_head
        assign left_data  = word;
        assign left_valid = 1'b1;
      end else begin : g_body
        assign left_data  = cell_data[i-1];
        assign left_valid = cell_valid[i-1];
      end

      if (i == DEPTH - 1) begin : g_tail
        assign right_data  = '0;
        assign right_valid = 1'b0;
      end else begin : g_inner
        assign right_data  = cell_data[i+1];
        assign right_valid = cell_valid[i+1];
      end

      dq_cell #(
        .DATA_WIDTH (DATA_WIDTH),
        .FIRST      (i == 0)
      ) u_cell (
        .clk         (clk),
        .rst_n       (rst_n),
        .op          (op),
        .word        (word),
        .left_data   (left_data),
        .left_valid  (left_valid),
        .right_data  (right_data),
        .right_valid (right_valid),
        .data_o      (cell_data[i]),
        .valid_o     (cell_valid[i]),
        .contrib     (cell_contrib[i])
      );
    end
  endgenerate

  dq_or_tree #(
    .N (DEPTH),
    .W (DATA_WIDTH + 1)
  ) u_tree (
    .clk  (clk),
    .load (accept),
    .leaf (cell_contrib),
    .root (root)
  );

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      dq_pkg::ST_IDLE: begin
        if (accept) begin
          state_nxt = dq_pkg::ST_REDUCE;
        end
      end
      dq_pkg::ST_REDUCE: begin
        if (tree_done) begin
          state_nxt = dq_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = dq_pkg::ST_IDLE;
      end
    endcase
  end

  always_comb begin
    in_beat.ready = (state_r == dq_pkg::ST_IDLE) && !out_valid_r;
    tree_done     = (state_r == dq_pkg::ST_REDUCE) && (cnt_r == CNT_W'(LEVELS));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= dq_pkg::ST_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (accept) begin
        cnt_r <= '0;
      end else if (state_r == dq_pkg::ST_REDUCE) begin
        cnt_r <= cnt_r + 1'b1;
      end
      if (tree_done) begin
        out_valid_r <= 1'b1;
      end else if (out_beat.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status_r <= status_nxt;
    end
    if (tree_done) begin
      out_popped_r <= popped;
      out_found_r  <= root[DATA_WIDTH];
      out_status_r <= status_r;
    end
  end

  assign out_beat.valid        = out_valid_r;
  assign out_beat.popped_value = out_popped_r;
  assign out_beat.found        = out_found_r;
  assign out_beat.status       = out_status_r;

endmodule

`default_nettype wire

// ===== design/dq_checker.sv =====
// Port-level checker for the double-ended queue, attached to the top level by a bind.
// Depends on dq_pkg for the status codes.
`default_nettype none

module dq_checker (
  input wire logic                              clk,
  input wire logic                              rst_n,
  input wire logic                              in_valid,
  input wire logic                              in_ready,
  input wire logic                              out_valid,
  input wire logic                              out_ready,
  input wire logic [dq_pkg::VALUE_WIDTH-1:0]    out_popped_value,
  input wire logic                              out_found,
  input wire logic [dq_pkg::STATUS_WIDTH-1:0]   out_status
);

  a_error_clean: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_status != dq_pkg::STATUS_OK) |-> (out_popped_value == '0) && !out_found)
    else $error("An error result carries a data word or a match.");

  a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_found |-> (out_status == dq_pkg::STATUS_OK))
    else $error("A match was reported together with an error status.");

  a_one_in_flight: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready |=> !in_ready)
    else $error("A second request beat was taken while one is still in flight.");

  a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_popped_value) && $stable(out_found)
      && $stable(out_status))
    else $error("A stalled result beat changed or vanished.");

  a_reset_quiet: assert property (@(posedge clk)
    !rst_n |=> !out_valid)
    else $error("A result beat is offered right after reset.");

endmodule

bind deque_with_membership_search dq_checker u_dq_checker (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_beat.valid),
  .in_ready         (in_beat.ready),
  .out_valid        (out_beat.valid),
  .out_ready        (out_beat.ready),
  .out_popped_value (out_beat.popped_value),
  .out_found        (out_beat.found),
  .out_status       (out_beat.status)
);

`default_nettype wire
